>>> hw/rtl/crc64_parameterized_engine_macros.svh
// assertion macros for the crc64 engine
`ifndef CRC64_PARAMETERIZED_ENGINE_MACROS_SVH
`define CRC64_PARAMETERIZED_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked on every rising edge out of reset
`define CRC64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("crc64 assertion failed");

// next-cycle implication
`define CRC64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("crc64 assertion failed");

`else

`define CRC64_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CRC64_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/crc64_pkg.sv
// shared widths, register indexes and bit-reversal helpers for the crc64 engine
package crc64_pkg;

	localparam int CRC_W     = 64;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	typedef logic [CRC_W-1:0]     crc_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;

	// configuration register indexes
	localparam cfg_idx_t REG_POLYNOMIAL     = cfg_idx_t'(0);
	localparam cfg_idx_t REG_INITIAL_VALUE  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_FINAL_XOR      = cfg_idx_t'(2);
	localparam cfg_idx_t REG_REFLECTED_MODE = cfg_idx_t'(3);
	localparam cfg_idx_t REG_REFLECT_INPUT  = cfg_idx_t'(4);
	localparam cfg_idx_t REG_REFLECT_OUTPUT = cfg_idx_t'(5);

	function automatic crc_t rev_crc(input crc_t v);
		crc_t r;
		r = '0;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = v[CRC_W-1-i];
		end
		return r;
	endfunction

	function automatic byte_t rev_byte(input byte_t v);
		byte_t r;
		r = '0;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/crc64_byte_if.sv
// byte input channel: valid/ready handshake with data byte and last flag
interface crc64_byte_if import crc64_pkg::*; ;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/crc64_crc_if.sv
// result channel: valid/ready handshake carrying the finished crc
interface crc64_crc_if import crc64_pkg::*; ;
	logic valid;
	logic ready;
	crc_t crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

>>> hw/rtl/crc64_parameterized_engine.sv
// top level of the parameterized crc64 engine: input stage, byte update, result register
//
// usage:
//   byte_in  - one message byte per item, last_byte marks the end of a message
//   crc_out  - one item per message, the finished crc, given after the last byte
//   cfg_*    - write port for polynomial, initial value, final xor and the three
//              reflection flags; write only while no message is in flight
// timing:
//   a byte is registered in the input stage, folded into the crc register in the
//   next cycle by an eight-step xor network, and for a last byte the result lands
//   in the output register: two cycles from byte accept to crc valid
//   one byte per cycle sustained; the input stage and the output register are
//   separate, so bytes keep flowing while a finished crc waits
// stall:
//   only a last byte needs the output register; if crc_out stalls with a result
//   still held, that last byte waits in the input stage and byte_in drops ready
//   until the result is taken; non-last bytes never wait
// reset:
//   all configuration registers clear to zero, both stages empty, and the engine
//   is armed so the first byte starts a new message from the initial value
`include "crc64_parameterized_engine_macros.svh"

module crc64_parameterized_engine import crc64_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_idx,
	input  cfg_data_t         cfg_data,
	crc64_byte_if.sink        byte_in,
	crc64_crc_if.source       crc_out
);

	// configuration registers
	crc_t  poly_q;
	crc_t  init_q;
	crc_t  fxor_q;
	logic  refl_mode_q;
	logic  refl_in_q;
	logic  refl_out_q;

	// input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// running crc state
	crc_t  crc_q;
	logic  armed_q;

	// output register
	logic  valid_s2;
	crc_t  crc_s2;

	// handshake
	logic  res_free;
	logic  s1_adv;
	logic  in_fire;

	// update network
	crc_t  crc_seed;
	crc_t  poly_rev;
	byte_t byte_eff;
	crc_t  crc_next;
	crc_t  crc_result;

	// config write, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q      <= '0;
			init_q      <= '0;
			fxor_q      <= '0;
			refl_mode_q <= 1'b0;
			refl_in_q   <= 1'b0;
			refl_out_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_POLYNOMIAL:     poly_q      <= cfg_data[CRC_W-1:0];
				REG_INITIAL_VALUE:  init_q      <= cfg_data[CRC_W-1:0];
				REG_FINAL_XOR:      fxor_q      <= cfg_data[CRC_W-1:0];
				REG_REFLECTED_MODE: refl_mode_q <= cfg_data[0];
				REG_REFLECT_INPUT:  refl_in_q   <= cfg_data[0];
				REG_REFLECT_OUTPUT: refl_out_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// output register is free when empty or being drained this cycle
	assign res_free = !valid_s2 || crc_out.ready;
	// a non-last byte always moves on; a last byte needs the output register
	assign s1_adv   = valid_s1 && (!last_s1 || res_free);
	assign byte_in.ready = !valid_s1 || s1_adv;
	assign in_fire  = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	// byte update: eight shift-and-xor steps, direction set by the mode
	always_comb begin
		crc_seed = armed_q ? init_q : crc_q;
		poly_rev = rev_crc(poly_q);
		byte_eff = refl_in_q ? rev_byte(byte_s1) : byte_s1;
		if (refl_mode_q) begin
			// lsb-first: byte into the low end, reversed polynomial, input flag ignored
			crc_next = crc_seed ^ CRC_W'(byte_s1);
			for (int i = 0; i < BYTE_W; i++) begin
				crc_next = crc_next[0] ? ((crc_next >> 1) ^ poly_rev) : (crc_next >> 1);
			end
		end else begin
			// msb-first: byte into the top end
			crc_next = crc_seed ^ (CRC_W'(byte_eff) << (CRC_W - BYTE_W));
			for (int i = 0; i < BYTE_W; i++) begin
				crc_next = crc_next[CRC_W-1] ? ((crc_next << 1) ^ poly_q) : (crc_next << 1);
			end
		end
		crc_result = (refl_out_q ? rev_crc(crc_next) : crc_next) ^ fxor_q;
	end

	// crc state; a last byte re-arms so the next byte seeds from the initial value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b1;
			crc_q   <= '0;
		end else if (s1_adv) begin
			armed_q <= last_s1;
			crc_q   <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (crc_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			crc_s2 <= crc_result;
		end
	end

	assign crc_out.valid     = valid_s2;
	assign crc_out.crc_value = crc_s2;

	// a consumed last byte always leaves a result and a re-armed engine
	`CRC64_ASSERT_NEXT(a_last_gives_result, clk, arst_n, s1_adv && last_s1, valid_s2)
	`CRC64_ASSERT_NEXT(a_last_rearms, clk, arst_n, s1_adv && last_s1, armed_q)
	// back-pressure only comes from a held last byte behind a stalled result
	`CRC64_ASSERT_NOW(a_stall_cause, clk, arst_n, !byte_in.ready,
		valid_s1 && last_s1 && valid_s2 && !crc_out.ready)
	// a held input stage keeps its byte
	`CRC64_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv,
		valid_s1 && $stable(byte_s1) && $stable(last_s1))

endmodule
